FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by file name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is high
`define UPDEC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("updec check failed");

// concurrent check that also holds across reset
`define UPDEC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("updec check failed");

`endif

FILE: hw/rtl/updec_pkg.sv
// types, character codes and helper functions for the url percent decoder
// no dependencies; imported by updec_core and url_percent_decoder
package updec_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] items;
    logic [1:0]                count;
  } group_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.nib = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.nib = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.nib = 4'(b - 8'h37);
    end
    return h;
  endfunction

  // upper-case hex character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else           c = 8'h37 + {4'd0, n};
    return c;
  endfunction

endpackage

FILE: hw/rtl/updec_core.sv
// escape state and per-byte decode: maps one byte to up to three results
// depends on updec_pkg
module updec_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output updec_pkg::group_t grp
);
  import updec_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] first_digit, first_digit_next;
  logic [1:0] n_cnt;
  logic       do_idle;
  hex_t       h;

  assign h = hex_value(in_byte);

  always_comb begin
    grp              = '0;
    n_cnt            = 2'd0;
    do_idle          = 1'b0;
    phase_next       = phase;
    first_digit_next = first_digit;
    case (phase)
      PH_PCT: begin
        if (h.ok) begin
          first_digit_next = h.nib;
          phase_next       = PH_DIGIT;
        end else begin
          grp.items[n_cnt] = '{data: CH_PERCENT, has: 1'b1, last: 1'b0};
          n_cnt            = n_cnt + 2'd1;
          do_idle          = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (h.ok) begin
          grp.items[n_cnt] = '{data: {first_digit, h.nib}, has: 1'b1, last: 1'b0};
          n_cnt            = n_cnt + 2'd1;
          phase_next       = PH_IDLE;
        end else begin
          grp.items[n_cnt] = '{data: CH_PERCENT, has: 1'b1, last: 1'b0};
          n_cnt            = n_cnt + 2'd1;
          grp.items[n_cnt] = '{data: hex_char(first_digit), has: 1'b1, last: 1'b0};
          n_cnt            = n_cnt + 2'd1;
          do_idle          = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // byte handled as in idle
    if (do_idle) begin
      if (in_byte == CH_PERCENT) begin
        phase_next = PH_PCT;
      end else begin
        grp.items[n_cnt] = '{data: (in_byte == CH_PLUS) ? CH_SPACE : in_byte,
                             has: 1'b1, last: 1'b0};
        n_cnt            = n_cnt + 2'd1;
        phase_next       = PH_IDLE;
      end
    end

    // end of string drops any pending escape
    if (in_last) begin
      phase_next       = PH_IDLE;
      first_digit_next = 4'd0;
      if (n_cnt == 2'd0) begin
        grp.items[0] = '{data: 8'h00, has: 1'b0, last: 1'b1};
        n_cnt        = 2'd1;
      end else begin
        grp.items[n_cnt - 2'd1].last = 1'b1;
      end
    end
    grp.count = n_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      first_digit <= 4'd0;
    end else if (step) begin
      phase       <= phase_next;
      first_digit <= first_digit_next;
    end
  end

endmodule

FILE: hw/rtl/url_percent_decoder.sv
// top level of the url percent decoder: input register, decode core, result buffer
// depends on updec_pkg and updec_core
//
// usage
//   s_axis carries escaped text one byte per transaction; tlast marks the final
//   byte of a string. m_axis carries decoded results: tdata is the byte, tuser
//   is has_byte (0 only for an end marker with tdata zero), tlast marks the
//   final result of the string.
//   '+' decodes to a space, '%' plus two hex digits to one byte; a broken
//   escape is passed on, its hex digit upper case. a pending escape at the end
//   of a string is dropped; a final byte that yields nothing gives an end marker.
// path: input register, then decode core, then result buffer.
// throughput: one byte per cycle while m_axis_tready is high and each byte yields
//   at most one result; a byte that yields two or three results holds the input
//   until the single-result output port has drained the result buffer.
// reset: synchronous, active high; clears the escape state and both buffers.
// stall: with m_axis_tready low the result buffer holds its data, the input
//   register still takes one more byte, then s_axis_tready falls.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // has_byte
  output logic       m_axis_tlast    // out_last
);
  import updec_pkg::*;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // result buffer, drained one result per transaction
  result_t [MAX_RESULTS-1:0] buf_items;
  logic [1:0]                buf_cnt;
  logic [1:0]                buf_idx;

  group_t grp;
  logic   s_accept;
  logic   m_accept;
  logic   buf_free;
  logic   step;

  assign m_accept = m_axis_tvalid & m_axis_tready;
  // buffer empty now or its final result leaves this cycle
  assign buf_free = (buf_cnt == 2'd0) || (m_accept && buf_cnt == 2'd1);
  assign step     = in_full & buf_free;
  assign s_axis_tready = ~in_full | step;
  assign s_accept = s_axis_tvalid & s_axis_tready;

  updec_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .grp     (grp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
      buf_idx <= 2'd0;
    end else if (step) begin
      buf_cnt <= grp.count;
      buf_idx <= 2'd0;
    end else if (m_accept) begin
      buf_cnt <= buf_cnt - 2'd1;
      buf_idx <= buf_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      buf_items <= grp.items;
    end
  end

  assign m_axis_tvalid = (buf_cnt != 2'd0);
  assign m_axis_tdata  = buf_items[buf_idx].data;
  assign m_axis_tuser  = buf_items[buf_idx].has;
  assign m_axis_tlast  = buf_items[buf_idx].last;

endmodule

FILE: hw/rtl/updec_checker.sv
// port-level checks for url_percent_decoder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module updec_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // stall conditions and the whole word offered on each side
  logic       s_stall;
  logic       m_stall;
  logic       m_marker;
  logic [8:0] s_word;
  logic [9:0] m_word;

  assign s_stall  = s_axis_tvalid && !s_axis_tready;
  assign m_stall  = m_axis_tvalid && !m_axis_tready;
  assign m_marker = m_axis_tvalid && !m_axis_tuser;
  assign s_word   = {s_axis_tlast, s_axis_tdata};
  assign m_word   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // nothing offered straight after reset
  `UPDEC_ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !m_axis_tvalid)

  // a stalled result stays offered and unchanged
  `UPDEC_ASSERT(a_hold_on_stall, clk, rst, m_stall |=> m_axis_tvalid && $stable(m_word))

  // a waiting input transaction stays offered and unchanged
  `UPDEC_ASSERT(a_in_hold_on_stall, clk, rst, s_stall |=> s_axis_tvalid && $stable(s_word))

  // an end marker closes the string and carries a zero byte
  `UPDEC_ASSERT(a_marker_form, clk, rst, m_marker |-> m_axis_tlast && (m_axis_tdata == 8'h00))

  // a result that is not the last of a string is never an end marker
  `UPDEC_ASSERT(a_data_before_end, clk, rst, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)

endmodule

bind url_percent_decoder updec_checker u_updec_checker (.*);

FILE: tb/tb_url_percent_decoder.sv
// self-checking testbench for url_percent_decoder: directed escapes, then random strings
// under several idle and stall patterns; depends on updec_pkg and the decoder rtl
module tb_url_percent_decoder;
  import updec_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic       m_axis_tuser;          // has_byte
  logic       m_axis_tlast;          // out_last

  // escape state of the predictor
  phase_t     esc_phase  = PH_IDLE;
  logic [3:0] esc_nibble = 4'd0;

  // decoded bytes still to come out of m_axis, oldest first
  result_t    decoded_q[$];

  int idle_pct   = 0;  // sender gap chance per cycle, in percent
  int stall_pct  = 0;  // receiver stall chance per cycle, in percent
  int bytes_sent = 0;
  int errors     = 0;

  url_percent_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // hex digit test, either case; nibble value through v
  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
      return 1'b1;
    end
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      // low nibble of 'a' and 'A' is 1, so adding 9 gives 10
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // hex character for a nibble, lower or upper case letters
  function automatic logic [7:0] digit_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'("0") + {4'd0, n};
    return (lower ? 8'("a") : 8'("A")) + {4'd0, n} - 8'd10;
  endfunction

  function automatic result_t data_result(input logic [7:0] d);
    return '{data: d, has: 1'b1, last: 1'b0};
  endfunction

  // byte seen with no escape open: returns 1 with the byte to emit, or opens an escape
  function automatic logic plain_byte(input logic [7:0] b, output logic [7:0] o);
    o = b;
    if (b == CH_PLUS) begin
      o = CH_SPACE;
      return 1'b1;
    end
    if (b == CH_PERCENT) begin
      esc_phase = PH_PCT;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // works out the results of one accepted byte and queues them
  function automatic void escape_decode(input logic [7:0] b, input logic last);
    result_t    got[$];
    logic [3:0] nib;
    logic [7:0] o;
    logic       is_hex;
    is_hex = hex_digit(b, nib);
    case (esc_phase)
      PH_PCT: begin
        if (is_hex) begin
          esc_nibble = nib;
          esc_phase  = PH_DIGIT;
        end else begin
          // broken escape: the percent goes out as it is, byte handled afresh
          got.push_back(data_result(CH_PERCENT));
          esc_phase = PH_IDLE;
          if (plain_byte(b, o)) got.push_back(data_result(o));
        end
      end
      PH_DIGIT: begin
        esc_phase = PH_IDLE;
        if (is_hex) begin
          got.push_back(data_result({esc_nibble, nib}));
        end else begin
          // percent plus the first digit, always upper case
          got.push_back(data_result(CH_PERCENT));
          got.push_back(data_result(digit_char(esc_nibble, 1'b0)));
          if (plain_byte(b, o)) got.push_back(data_result(o));
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        if (plain_byte(b, o)) got.push_back(data_result(o));
      end
    endcase
    if (last) begin
      // pending escape is dropped; an empty end still needs a marker
      esc_phase  = PH_IDLE;
      esc_nibble = 4'd0;
      if (got.size() == 0) got.push_back('{data: 8'h00, has: 1'b0, last: 1'b1});
      else got[got.size()-1].last = 1'b1;
    end
    foreach (got[i]) decoded_q.push_back(got[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls and checking of every transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual data=%h has=%b last=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.has ||
            m_axis_tlast !== want.last) begin
          $display("%0t: mismatch: expected data=%h has=%b last=%b, actual data=%h has=%b last=%b",
                   $time, want.data, want.has, want.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // one input transaction, with random gaps ahead of it; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    escape_decode(b, last);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last && (i == s.len() - 1));
  endtask

  // sender goes quiet until every queued result has been seen
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // one string built from well-formed escapes, plus signs, broken escapes and noise
  task automatic send_random_string();
    logic [7:0] q[$];
    int         n_tok;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          q.push_back(CH_PERCENT);
          q.push_back(digit_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          q.push_back(digit_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        4: q.push_back(CH_PLUS);
        5: begin
          q.push_back(CH_PERCENT);
          q.push_back(8'($urandom_range(0, 255)));
        end
        6: begin
          q.push_back(CH_PERCENT);
          q.push_back(digit_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          q.push_back(8'($urandom_range(0, 255)));
        end
        default: q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // now and then drop the final byte, which can leave an escape pending at the end
    if (q.size() > 1 && $urandom_range(0, 4) == 0) void'(q.pop_back());
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  task automatic run_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // escape extremes, broken escapes and string ends, no idling
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_text("%4a", 1'b0);     // lower-case digit
    send_text("%Ff", 1'b0);     // all ones, mixed case
    send_text("%00", 1'b0);     // all zeros
    send_text("+", 1'b0);       // plus to space
    send_text("%+", 1'b0);      // non-hex after percent, then plus
    send_text("%b:", 1'b0);     // non-hex second digit, digit comes back upper case
    send_byte(8'hFF, 1'b0);     // utf-8 style bytes pass straight through
    send_byte(8'h00, 1'b0);
    send_text("%", 1'b1);       // percent pending at the end: only a marker
    send_text("%a", 1'b1);      // percent and digit pending at the end: marker
    send_text("x", 1'b1);       // plain final byte carries the last flag
    wait_drained();
  endtask

  task automatic test_streaming();
    idle_pct  = 0;
    stall_pct = 0;
    run_random(100);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 46;
    stall_pct = 0;
    run_random(100);
  endtask

  // stalls, with one full drain part way so the input side sits idle
  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 46;
    run_random(50);
    wait_drained();
    run_random(50);
  endtask

  task automatic test_both_idle();
    idle_pct  = 12;
    stall_pct = 12;
    run_random(100);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    wait_drained();
    // give any stray result time to show up
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/updec_pkg.sv
hw/rtl/updec_core.sv
hw/rtl/url_percent_decoder.sv
hw/rtl/updec_checker.sv
tb/tb_url_percent_decoder.sv
